FILE: sv/http_body_deframer_core_defines.svh
// Assertion macros shared by the body deframer modules.
`ifndef HTTP_BODY_DEFRAMER_CORE_DEFINES_SVH
`define HTTP_BODY_DEFRAMER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define HBD_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define HBD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/hbd_pkg.sv
// Types, constants and helper functions for the HTTP body deframer.
package hbd_pkg;

    // Width of the internal body byte counter; the result field is 32 bits.
    localparam int COUNT_BITS = 32;
    localparam int SUM_W      = ((COUNT_BITS > 32) ? COUNT_BITS : 32) + 1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [31:0]           SHOWN_MAX = '1;

    // Result queue geometry. Input is held off once fewer than FIFO_SLACK
    // slots are free: one item in the input register and one being accepted
    // can each push two results.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int FIFO_SLACK = 4;

    // Configuration register indexes.
    localparam logic CFG_IDX_MODE   = 1'b0;
    localparam logic CFG_IDX_LENGTH = 1'b1;

    // Closing status codes.
    localparam logic [1:0] ST_COMPLETE  = 2'd0;
    localparam logic [1:0] ST_TRUNCATED = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;

    // Characters of interest.
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UPPERA = 8'h41;
    localparam logic [7:0] CH_UPPERF = 8'h46;
    localparam logic [7:0] CH_LOWERA = 8'h61;
    localparam logic [7:0] CH_LOWERF = 8'h66;

    typedef enum logic [2:0] {
        PH_SIZE,
        PH_DATA,
        PH_DATA_END,
        PH_DATA_CR,
        PH_TRAILER,
        PH_BAD
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_body;
    } src_item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_final;
        logic [1:0]  status;
        logic [31:0] body_count;
    } res_item_t;

    // Results produced by one input item: n of them, r0 first.
    typedef struct packed {
        logic [1:0] n;
        res_item_t  r0;
        res_item_t  r1;
    } push_t;

    // {valid, value} of a hex digit character.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c inside {[CH_ZERO:CH_NINE]}) begin
            r = {1'b1, 4'(c - CH_ZERO)};
        end
        else if (c inside {[CH_LOWERA:CH_LOWERF]}) begin
            r = {1'b1, 4'(c - CH_LOWERA + 8'd10)};
        end
        else if (c inside {[CH_UPPERA:CH_UPPERF]}) begin
            r = {1'b1, 4'(c - CH_UPPERA + 8'd10)};
        end
        return r;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c inside {CH_SPACE, CH_TAB, CH_CR, CH_VT, CH_FF};
    endfunction

    // Clamp the internal count to the 32-bit result field.
    function automatic logic [31:0] shown_count(input logic [COUNT_BITS-1:0] cnt);
        logic [SUM_W-1:0] wide;
        wide = SUM_W'(cnt);
        return (wide > SUM_W'(SHOWN_MAX)) ? SHOWN_MAX : wide[31:0];
    endfunction

endpackage

FILE: sv/http_body_deframer_core.sv
// Top level of the HTTP body deframer: config registers, input register, decode, result queue.
//
// Usage:
//   src_valid/src_stall/src_item carry body bytes, one per transfer, with
//   end_of_body set on the last byte. res_valid/res_stall/res_item carry the
//   results: one per passed body byte, then one closing status result per body.
//   cfg_we/cfg_index/cfg_data write framing_mode (index 0) and the declared
//   body length (index 1); write only while no body is in flight. The mode is
//   latched on the first byte of each body.
// Path: a byte taken from src is held in the input register, decoded, and
//   its results are written into the result queue, which drives res_item.
// Throughput: one byte per cycle while src_stall is low. The closing byte of a
//   body may yield two results; the eight-entry result queue soaks those up while
//   output drains one result per cycle unless res_stall is high. src_stall rises
//   when fewer than four queue slots are free, room for the input register's item plus one more.
// Reset: rst_n clears the config registers, the framing state and the queue;
//   no result is pending afterwards.
// Receiver stall: while res_stall is high the head result holds; the queue
//   fills and src_stall then holds off the sender. No result is dropped.

module http_body_deframer_core
    import hbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        src_valid,
    output logic        src_stall,
    input  src_item_t   src_item,
    output logic        res_valid,
    input  logic        res_stall,
    output res_item_t   res_item,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    logic        framing_mode_reg;
    logic [31:0] length_limit_reg;
    logic        item_valid_reg, item_valid_next;
    src_item_t   item_reg;
    logic        room;
    push_t       push;

    // Configuration writes: no wait state, no read-back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            framing_mode_reg <= 1'b0;
            length_limit_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IDX_MODE:   framing_mode_reg <= cfg_data[0];
                CFG_IDX_LENGTH: length_limit_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Hold off the sender while fewer than four queue slots are free.
    assign src_stall       = !room;
    assign item_valid_next = src_valid && !src_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    // Capture the byte on every transfer; payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (item_valid_next)
        begin
            item_reg <= src_item;
        end
    end

    hbd_decode u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .framing_mode (framing_mode_reg),
        .length_limit (length_limit_reg),
        .item_valid   (item_valid_reg),
        .item         (item_reg),
        .push         (push)
    );

    hbd_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

endmodule

FILE: sv/hbd_decode.sv
// Per-byte framing state machine: chunk size parsing, data pass and status.
`include "http_body_deframer_core_defines.svh"

module hbd_decode
    import hbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        framing_mode,
    input  logic [31:0] length_limit,
    input  logic        item_valid,
    input  src_item_t   item,
    output push_t       push
);

    phase_t                phase_reg, phase_next;
    logic [31:0]           size_accum_reg, size_accum_next;
    logic                  saw_digit_reg, saw_digit_next;
    logic                  digits_done_reg, digits_done_next;
    logic                  bad_line_reg, bad_line_next;
    logic [31:0]           remaining_reg, remaining_next;
    logic [31:0]           chunk_length_reg, chunk_length_next;
    logic [COUNT_BITS-1:0] committed_reg, committed_next;
    logic                  active_reg, active_next;
    logic                  use_chunked_reg, use_chunked_next;
    logic                  limited_reg, limited_next;

    logic                  first;
    logic                  use_ch;
    logic                  lim;
    logic [31:0]           rem;
    phase_t                ph;
    logic [7:0]            ch;
    logic [4:0]            hex;
    logic                  pass;
    logic                  add_en;
    logic [31:0]           add_amt;
    logic [SUM_W-1:0]      sum;
    logic [COUNT_BITS-1:0] count_new;
    logic [31:0]           shown;
    logic [1:0]            fin_status;
    res_item_t             data_res;
    res_item_t             fin_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_SIZE;
            size_accum_reg   <= '0;
            saw_digit_reg    <= 1'b0;
            digits_done_reg  <= 1'b0;
            bad_line_reg     <= 1'b0;
            remaining_reg    <= '0;
            chunk_length_reg <= '0;
            committed_reg    <= '0;
            active_reg       <= 1'b0;
            use_chunked_reg  <= 1'b0;
            limited_reg      <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            size_accum_reg   <= size_accum_next;
            saw_digit_reg    <= saw_digit_next;
            digits_done_reg  <= digits_done_next;
            bad_line_reg     <= bad_line_next;
            remaining_reg    <= remaining_next;
            chunk_length_reg <= chunk_length_next;
            committed_reg    <= committed_next;
            active_reg       <= active_next;
            use_chunked_reg  <= use_chunked_next;
            limited_reg      <= limited_next;
        end
    end

    always_comb
    begin
        phase_next        = phase_reg;
        size_accum_next   = size_accum_reg;
        saw_digit_next    = saw_digit_reg;
        digits_done_next  = digits_done_reg;
        bad_line_next     = bad_line_reg;
        remaining_next    = remaining_reg;
        chunk_length_next = chunk_length_reg;
        active_next       = active_reg;
        use_chunked_next  = use_chunked_reg;
        limited_next      = limited_reg;
        pass              = 1'b0;
        add_en            = 1'b0;
        add_amt           = 32'd1;

        // Latch the mode on the first byte of a body.
        first  = !active_reg;
        use_ch = first ? framing_mode : use_chunked_reg;
        lim    = first ? (length_limit != 32'd0) : limited_reg;
        rem    = first ? (framing_mode ? 32'd0 : length_limit) : remaining_reg;
        ph     = first ? PH_SIZE : phase_reg;
        ch     = item.data_byte;
        hex    = hex_digit(ch);

        if (item_valid)
        begin
            active_next      = 1'b1;
            use_chunked_next = use_ch;
            limited_next     = lim;
            remaining_next   = rem;
            phase_next       = ph;

            if (use_ch)
            begin
                case (ph)
                    PH_SIZE:
                    begin
                        if (ch == CH_LF)
                        begin
                            if (bad_line_reg || !saw_digit_reg)
                            begin
                                phase_next = PH_BAD;
                            end
                            else if (size_accum_reg == 32'd0)
                            begin
                                phase_next = PH_TRAILER;
                            end
                            else
                            begin
                                remaining_next    = size_accum_reg;
                                chunk_length_next = size_accum_reg;
                                phase_next        = PH_DATA;
                            end
                            size_accum_next  = '0;
                            saw_digit_next   = 1'b0;
                            digits_done_next = 1'b0;
                            bad_line_next    = 1'b0;
                        end
                        else if (!digits_done_reg)
                        begin
                            if (hex[4])
                            begin
                                // one more digit on a size whose top nibble is set overflows
                                if (size_accum_reg[31:28] != 4'd0)
                                begin
                                    bad_line_next = 1'b1;
                                end
                                else
                                begin
                                    size_accum_next = {size_accum_reg[27:0], hex[3:0]};
                                end
                                saw_digit_next = 1'b1;
                            end
                            else if (!saw_digit_reg && is_blank(ch))
                            begin
                                // skip leading white space
                            end
                            else
                            begin
                                digits_done_next = 1'b1;
                                if (!saw_digit_reg)
                                begin
                                    bad_line_next = 1'b1;
                                end
                            end
                        end
                    end
                    PH_DATA:
                    begin
                        pass           = 1'b1;
                        remaining_next = rem - 32'd1;
                        if (rem == 32'd1)
                        begin
                            add_en     = 1'b1;
                            add_amt    = chunk_length_reg;
                            phase_next = PH_DATA_END;
                        end
                    end
                    PH_DATA_END:
                    begin
                        if (ch == CH_CR)
                        begin
                            phase_next = PH_DATA_CR;
                        end
                        else if (ch == CH_LF)
                        begin
                            phase_next = PH_SIZE;
                        end
                        else
                        begin
                            phase_next = PH_BAD;
                        end
                    end
                    PH_DATA_CR:
                    begin
                        phase_next = (ch == CH_LF) ? PH_SIZE : PH_BAD;
                    end
                    default:
                    begin
                        // trailer and malformed bodies drop every byte
                    end
                endcase
            end
            else if (!lim)
            begin
                pass   = 1'b1;
                add_en = 1'b1;
            end
            else if (rem != 32'd0)
            begin
                pass           = 1'b1;
                add_en         = 1'b1;
                remaining_next = rem - 32'd1;
            end
        end

        // Saturating count update.
        sum = SUM_W'(committed_reg) + SUM_W'(add_amt);
        if (!add_en)
        begin
            count_new = committed_reg;
        end
        else if (sum > SUM_W'(COUNT_MAX))
        begin
            count_new = COUNT_MAX;
        end
        else
        begin
            count_new = sum[COUNT_BITS-1:0];
        end
        committed_next = count_new;
        shown          = shown_count(count_new);

        if (use_ch)
        begin
            case (phase_next)
                PH_TRAILER: fin_status = ST_COMPLETE;
                PH_BAD:     fin_status = ST_MALFORMED;
                default:    fin_status = ST_TRUNCATED;
            endcase
        end
        else
        begin
            fin_status = (!lim || remaining_next == 32'd0) ? ST_COMPLETE : ST_TRUNCATED;
        end

        data_res.out_byte   = ch;
        data_res.is_final   = 1'b0;
        data_res.status     = ST_COMPLETE;
        data_res.body_count = shown;

        fin_res.out_byte    = 8'd0;
        fin_res.is_final    = 1'b1;
        fin_res.status      = fin_status;
        fin_res.body_count  = shown;

        push.n  = item_valid ? (2'(pass) + 2'(item.end_of_body)) : 2'd0;
        push.r0 = pass ? data_res : fin_res;
        push.r1 = fin_res;

        // Close the body: return to the idle state.
        if (item_valid && item.end_of_body)
        begin
            phase_next        = PH_SIZE;
            size_accum_next   = '0;
            saw_digit_next    = 1'b0;
            digits_done_next  = 1'b0;
            bad_line_next     = 1'b0;
            remaining_next    = '0;
            chunk_length_next = '0;
            committed_next    = '0;
            active_next       = 1'b0;
            use_chunked_next  = 1'b0;
            limited_next      = 1'b0;
        end
    end

    `HBD_ASSERT_NEXT(a_body_closes, item_valid && item.end_of_body, !active_reg && phase_reg == PH_SIZE && committed_reg == '0, "deframer did not return to idle after end of body")
    `HBD_ASSERT_IMPLY(a_data_has_bytes, phase_reg == PH_DATA, remaining_reg != 32'd0, "data phase with no bytes left")
    `HBD_ASSERT_IMPLY(a_no_push_when_idle, !item_valid, push.n == 2'd0, "results pushed without an input item")

endmodule

FILE: sv/hbd_out_fifo.sv
// Result queue: takes up to two results a cycle, delivers one a cycle while res_stall is low.
`include "http_body_deframer_core_defines.svh"

module hbd_out_fifo
    import hbd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  push_t     push,
    output logic      room,
    output logic      res_valid,
    input  logic      res_stall,
    output res_item_t res_item
);

    res_item_t             ring_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]    head_reg, head_next;
    logic [FIFO_AW-1:0]    tail_reg, tail_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic [FIFO_AW-1:0]    tail_plus1;
    logic                  pop;

    assign res_valid  = (count_reg != '0);
    assign res_item   = ring_reg[head_reg];
    assign pop        = res_valid && !res_stall;
    assign room       = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - FIFO_SLACK));
    assign tail_plus1 = tail_reg + FIFO_AW'(1);

    always_comb
    begin
        head_next  = pop ? (head_reg + FIFO_AW'(1)) : head_reg;
        tail_next  = tail_reg + FIFO_AW'(push.n);
        count_next = count_reg + FIFO_CNT_W'(push.n) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Entries are payload only; validity lives in count_reg.
    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
        begin
            ring_reg[tail_reg] <= push.r0;
        end
        if (push.n == 2'd2)
        begin
            ring_reg[tail_plus1] <= push.r1;
        end
    end

    `HBD_ASSERT_IMPLY(a_no_overflow, push.n != 2'd0, (FIFO_CNT_W + 1)'(count_reg) + (FIFO_CNT_W + 1)'(push.n) <= (FIFO_CNT_W + 1)'(FIFO_DEPTH) + (FIFO_CNT_W + 1)'(pop), "result queue overflow")
    `HBD_ASSERT_IMPLY(a_count_bound, 1'b1, count_reg <= FIFO_CNT_W'(FIFO_DEPTH), "result queue count out of range")
    `HBD_ASSERT_NEXT(a_count_holds, push.n == 2'd0 && !pop, $stable(count_reg), "queue count moved with no push or pop")

endmodule
